@@ rtl/thur_pkg.sv @@
// ----------------------------------------------------------------------------
// thur_pkg
// Shared types and constants for the trace history undo/redo core.
// ----------------------------------------------------------------------------
package thur_pkg;

  localparam int unsigned VALUE_W   = 32;
  localparam int unsigned TYPE_W    = 2;
  localparam int unsigned HELD_W    = 6;
  localparam int unsigned S_TDATA_W = 96;
  localparam int unsigned S_TUSER_W = 4;
  localparam int unsigned M_TDATA_W = 72;
  localparam int unsigned M_TUSER_W = 2;

  // Bit positions inside m_tuser.
  localparam int unsigned TUSER_RESTORE_BIT = 0;
  localparam int unsigned TUSER_END_BIT     = 1;

  typedef enum logic [1:0] {
    OP_RECORD = 2'd0,
    OP_UNDO   = 2'd1,
    OP_REDO   = 2'd2,
    OP_WIPE   = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    CMD_STORE,
    CMD_SKIP,
    CMD_UNDO,
    CMD_REDO,
    CMD_WIPE
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e                   kind;
    logic [TYPE_W-1:0]           ctype;
    logic signed [VALUE_W-1:0]   target_id;
    logic [VALUE_W-1:0]          old_value;
    logic [VALUE_W-1:0]          new_value;
  } cmd_t;

  typedef struct packed {
    logic                        restore_valid;
    logic signed [VALUE_W-1:0]   restore_id;
    logic [VALUE_W-1:0]          restore_value;
    logic                        last;
    logic                        end_reached;
    logic [HELD_W-1:0]           entries_held;
  } result_t;

endpackage

@@ rtl/thur_front.sv @@
// ----------------------------------------------------------------------------
// thur_front
// Holds the record enable register and classifies incoming transactions.
// ----------------------------------------------------------------------------
module thur_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic                           cfg_data_i,
  input  logic                           s_tvalid_i,
  output logic                           s_tready_o,
  input  logic [thur_pkg::S_TDATA_W-1:0] s_tdata_i,
  input  logic [thur_pkg::S_TUSER_W-1:0] s_tuser_i,
  output logic                           push_valid_o,
  input  logic                           push_ready_i,
  output thur_pkg::cmd_t                 push_cmd_o
);
  import thur_pkg::*;

  logic    rec_en_q, rec_en_d;
  opcode_e opcode;
  logic [TYPE_W-1:0]  ctype;
  logic [VALUE_W-1:0] old_value, new_value;

  assign cfg_ready_o = 1'b1;
  assign rec_en_d    = (cfg_valid_i) ? cfg_data_i : rec_en_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_en_q <= 1'b0;
    end else begin
      rec_en_q <= rec_en_d;
    end
  end

  assign opcode    = opcode_e'(s_tuser_i[1:0]);
  assign ctype     = s_tuser_i[3:2];
  assign old_value = s_tdata_i[63:32];
  assign new_value = s_tdata_i[95:64];

  // A record that changes nothing and carries no mark is turned into a no-op here.
  always_comb begin
    push_cmd_o.ctype     = ctype;
    push_cmd_o.target_id = s_tdata_i[31:0];
    push_cmd_o.old_value = old_value;
    push_cmd_o.new_value = new_value;
    case (opcode)
      OP_RECORD: begin
        if (rec_en_q && ((old_value != new_value) || (ctype != '0))) begin
          push_cmd_o.kind = CMD_STORE;
        end else begin
          push_cmd_o.kind = CMD_SKIP;
        end
      end
      OP_UNDO: push_cmd_o.kind = CMD_UNDO;
      OP_REDO: push_cmd_o.kind = CMD_REDO;
      OP_WIPE: push_cmd_o.kind = CMD_WIPE;
      default: push_cmd_o.kind = CMD_SKIP;
    endcase
  end

  assign push_valid_o = s_tvalid_i;
  assign s_tready_o   = push_ready_i;

endmodule

@@ rtl/thur_cmd_queue.sv @@
// ----------------------------------------------------------------------------
// thur_cmd_queue
// Two-entry queue of classified commands between front and back.
// ----------------------------------------------------------------------------
module thur_cmd_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  thur_pkg::cmd_t push_cmd_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output thur_pkg::cmd_t pop_cmd_o
);
  import thur_pkg::*;

  cmd_t       slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       do_push, do_pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_cmd_o    = slot_q[rd_ptr_q];

  assign do_push  = push_valid_i && push_ready_o;
  assign do_pop   = pop_valid_o && pop_ready_i;
  assign wr_ptr_d = wr_ptr_q ^ do_push;
  assign rd_ptr_d = rd_ptr_q ^ do_pop;

  always_comb begin
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 2'd1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

@@ rtl/thur_back.sv @@
// ----------------------------------------------------------------------------
// thur_back
// History ring, pointers and the undo/redo walker with its result register.
// ----------------------------------------------------------------------------
module thur_back #(
  parameter int unsigned DEPTH_LOG2 = 6
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  output logic              cmd_ready_o,
  input  thur_pkg::cmd_t    cmd_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output thur_pkg::result_t res_o
);
  import thur_pkg::*;

  localparam int unsigned RING_SIZE = 1 << DEPTH_LOG2;
  localparam logic [DEPTH_LOG2-1:0] RING_MASK = '1;
  localparam logic [DEPTH_LOG2-1:0] PTR_ONE   = DEPTH_LOG2'(1);

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } state_e;

  typedef struct packed {
    logic [TYPE_W-1:0]         ctype;
    logic signed [VALUE_W-1:0] target_id;
    logic [VALUE_W-1:0]        old_value;
    logic [VALUE_W-1:0]        new_value;
  } entry_t;

  entry_t ring_q [RING_SIZE];
  entry_t rd_q;
  entry_t wr_entry;

  state_e                state_q, state_d;
  logic [DEPTH_LOG2-1:0] head_q, head_d, tail_q, tail_d, here_q, here_d;
  logic [DEPTH_LOG2-1:0] cnt_q, cnt_d;
  logic                  undo_q, undo_d;
  result_t               out_q, out_d;
  logic                  out_valid_q, out_valid_d;

  logic                  out_free, load_out, wr_en, rd_en;
  logic [DEPTH_LOG2-1:0] rd_addr, held_now, step_here, limit, cnt_next, rec_tail;
  logic                  at_end, group_end;

  assign out_free  = !out_valid_q || res_ready_i;
  assign held_now  = head_q - tail_q;
  assign step_here = undo_q ? (here_q - PTR_ONE) : (here_q + PTR_ONE);
  assign limit     = undo_q ? tail_q : head_q;
  assign cnt_next  = cnt_q + PTR_ONE;
  assign at_end    = (step_here == limit) || (cnt_next == RING_MASK);
  assign group_end = rd_q.ctype[1];
  // A full ring drops its oldest entry to make room.
  assign rec_tail  = ((here_q - tail_q) == RING_MASK) ? (tail_q + PTR_ONE) : tail_q;

  assign wr_entry.ctype     = cmd_i.ctype;
  assign wr_entry.target_id = cmd_i.target_id;
  assign wr_entry.old_value = cmd_i.old_value;
  assign wr_entry.new_value = cmd_i.new_value;

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    tail_d      = tail_q;
    here_d      = here_q;
    cnt_d       = cnt_q;
    undo_d      = undo_q;
    out_d       = out_q;
    load_out    = 1'b0;
    wr_en       = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = here_q;
    cmd_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i && out_free) begin
          cmd_ready_o         = 1'b1;
          load_out            = 1'b1;
          out_d.restore_valid = 1'b0;
          out_d.restore_id    = '0;
          out_d.restore_value = '0;
          out_d.last          = 1'b1;
          out_d.end_reached   = 1'b0;
          out_d.entries_held  = HELD_W'(held_now);
          case (cmd_i.kind)
            CMD_STORE: begin
              wr_en              = 1'b1;
              tail_d             = rec_tail;
              head_d             = here_q + PTR_ONE;
              here_d             = here_q + PTR_ONE;
              out_d.entries_held = HELD_W'(DEPTH_LOG2'(here_q + PTR_ONE - rec_tail));
            end
            CMD_WIPE: begin
              head_d             = '0;
              tail_d             = '0;
              here_d             = '0;
              out_d.entries_held = '0;
            end
            CMD_UNDO: begin
              if (here_q == tail_q) begin
                out_d.end_reached = 1'b1;
              end else begin
                load_out = 1'b0;
                rd_en    = 1'b1;
                rd_addr  = here_q - PTR_ONE;
                undo_d   = 1'b1;
                cnt_d    = '0;
                state_d  = ST_WALK;
              end
            end
            CMD_REDO: begin
              if (here_q == head_q) begin
                out_d.end_reached = 1'b1;
              end else begin
                load_out = 1'b0;
                rd_en    = 1'b1;
                rd_addr  = here_q;
                undo_d   = 1'b0;
                cnt_d    = '0;
                state_d  = ST_WALK;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_WALK: begin
        if (out_free) begin
          load_out            = 1'b1;
          out_d.restore_valid = 1'b1;
          out_d.restore_id    = rd_q.target_id;
          out_d.restore_value = undo_q ? rd_q.old_value : rd_q.new_value;
          out_d.last          = group_end || at_end;
          out_d.end_reached   = !group_end && at_end;
          out_d.entries_held  = HELD_W'(held_now);
          here_d              = step_here;
          cnt_d               = cnt_next;
          if (group_end || at_end) begin
            state_d = ST_IDLE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = undo_q ? (step_here - PTR_ONE) : step_here;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (res_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      here_q      <= '0;
      cnt_q       <= '0;
      undo_q      <= 1'b0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      here_q      <= here_d;
      cnt_q       <= cnt_d;
      undo_q      <= undo_d;
      out_q       <= out_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Writes land at the current position; the read port feeds the walker.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      ring_q[here_q] <= wr_entry;
    end
    if (rd_en) begin
      rd_q <= ring_q[rd_addr];
    end
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

endmodule

@@ rtl/trace_history_undo_redo_core.sv @@
// ----------------------------------------------------------------------------
// trace_history_undo_redo_core
// Undo/redo history ring for stepping a machine backwards and forwards.
// ----------------------------------------------------------------------------
// Record, wipe and ignored-record transactions each give one result and are
// taken at one per cycle as long as the result side keeps up; a record costs
// one write into the history memory. An undo or redo first reads one entry
// from the memory and then gives one restore per cycle as long as the
// result side keeps up; an undo or redo that finds itself at the end of the
// history answers with a single result and no memory read. The walk
// rate is set by the registered read port of the history memory. A two-entry
// command queue sits between the input side and the walker, so new items are
// taken while a walk or a stalled result is in progress. The memory has no
// reset and needs no clearing pass: only entries between tail and head are
// ever read. The ring holds at most 2^DEPTH_LOG2 - 1 changes; when full, a
// new record drops the oldest one.
// ----------------------------------------------------------------------------
module trace_history_undo_redo_core #(
  parameter int unsigned DEPTH_LOG2 = 6  // 2 to 6
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration: cfg_data_i is record_enable.
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic                           cfg_data_i,
  // Input stream.
  input  logic                           s_tvalid_i,
  output logic                           s_tready_o,
  // s_tdata_i: target_id[31:0], old_value[63:32], new_value[95:64]
  input  logic [thur_pkg::S_TDATA_W-1:0] s_tdata_i,
  // s_tuser_i: opcode[1:0], change_type[3:2]
  input  logic [thur_pkg::S_TUSER_W-1:0] s_tuser_i,
  // Result stream; m_tlast_o marks the final result of one input transaction.
  output logic                           m_tvalid_o,
  input  logic                           m_tready_i,
  // m_tdata_o: restore_id[31:0], restore_value[63:32], entries_held[69:64],
  //            zero fill[71:70]
  output logic [thur_pkg::M_TDATA_W-1:0] m_tdata_o,
  output logic                           m_tlast_o,
  // m_tuser_o: restore_valid[0], end_reached[1]
  output logic [thur_pkg::M_TUSER_W-1:0] m_tuser_o
);
  import thur_pkg::*;

  logic    push_valid, push_ready, pop_valid, pop_ready;
  cmd_t    push_cmd, pop_cmd;
  result_t result;

  // The front end owns the record enable and folds it into the command kind,
  // so the back end never has to look at configuration.
  thur_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .s_tvalid_i   (s_tvalid_i),
    .s_tready_o   (s_tready_o),
    .s_tdata_i    (s_tdata_i),
    .s_tuser_i    (s_tuser_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_cmd_o   (push_cmd)
  );

  thur_cmd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_cmd_i   (push_cmd),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_cmd_o    (pop_cmd)
  );

  // The back end holds the history memory, the pointers and the result
  // register that decouples it from the downstream consumer.
  thur_back #(
    .DEPTH_LOG2 (DEPTH_LOG2)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (pop_valid),
    .cmd_ready_o (pop_ready),
    .cmd_i       (pop_cmd),
    .res_valid_o (m_tvalid_o),
    .res_ready_i (m_tready_i),
    .res_o       (result)
  );

  assign m_tdata_o = {2'b00, result.entries_held, result.restore_value,
                      result.restore_id};
  assign m_tlast_o = result.last;
  assign m_tuser_o = {result.end_reached, result.restore_valid};

endmodule

@@ rtl/thur_checker.sv @@
// ----------------------------------------------------------------------------
// thur_checker
// Port-level checks on the result stream of the undo/redo core.
// ----------------------------------------------------------------------------
module thur_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           m_tvalid_o,
  input logic                           m_tready_i,
  input logic [thur_pkg::M_TDATA_W-1:0] m_tdata_o,
  input logic                           m_tlast_o,
  input logic [thur_pkg::M_TUSER_W-1:0] m_tuser_o
);
  import thur_pkg::*;

  // The end flag only appears on the closing result of a transaction.
  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && m_tuser_o[TUSER_END_BIT]) |-> m_tlast_o)
    else $error("end_reached set on a result that is not last");

  // A result with no restore is always the only result of its transaction.
  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && !m_tuser_o[TUSER_RESTORE_BIT]) |-> m_tlast_o)
    else $error("result without restore is not marked last");

  // A result with no restore carries zero location and value.
  a_empty_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && !m_tuser_o[TUSER_RESTORE_BIT]) |-> (m_tdata_o[63:0] == 64'd0))
    else $error("result without restore carries data");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && !m_tready_i) |=> (m_tvalid_o && $stable(m_tdata_o)))
    else $error("stalled result changed");

endmodule

bind trace_history_undo_redo_core thur_checker u_thur_checker (.*);
